/* hdl/assert_macros.svh */
// Assertion helpers used by hdl/papb_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, masked while reset is high.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds through reset.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hdl/papb_pkg.sv */
package papb_pkg;

   localparam int POS_W    = 9;
   localparam int SAMPLE_W = 16;
   localparam int PED_W    = 17;
   localparam int SUM_W    = 32;
   localparam int ADD_W    = 18;
   localparam int SHIFT_W  = 3;

   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 3;

   // command codes
   localparam logic [1:0] CMD_LOAD  = 2'd0;
   localparam logic [1:0] CMD_PIXEL = 2'd1;
   localparam logic [1:0] CMD_READ  = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_BIN_SHIFT = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_BYPASS    = 1'b1;

   localparam logic [PED_W-1:0]   PED_OFFSET = 17'h10000;
   localparam logic [SHIFT_W-1:0] SHIFT_MAX  = 3'd4;

   typedef struct packed {
      logic [1:0]          command;
      logic [POS_W-1:0]    row;
      logic [POS_W-1:0]    column;
      logic [SAMPLE_W-1:0] sample;
      logic [PED_W-1:0]    pedestal_word;
   } papb_req_type;

   typedef struct packed {
      logic [SUM_W-1:0] bin_sum;
      logic             saturated;
   } papb_rsp_type;

   // one entry of the bin memory
   typedef struct packed {
      logic             saturated;
      logic [SUM_W-1:0] sum;
   } papb_bin_type;

endpackage

/* hdl/papb_ram.sv */
module papb_ram #(
   parameter int WIDTH = 17,
   parameter int DEPTH = 262144,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hdl/pedestal_add_pixel_binner_unit.sv */
// Pedestal correction with pixel binning. A load word (command 0) stores one 17-bit pedestal
// at (row, column). A pixel word (command 1) adds its 16-bit sample to the stored pedestal,
// or to 65536 when pedestal_bypass is set, and accumulates the result into bin (row >> shift,
// column >> shift), with shift the bin_shift register clamped to 4, saturating at 2^32-1 and
// setting the bin's sticky saturated flag; it reads both memories, forms the corrected value,
// then adds and writes back. A read word (command 2) returns one bin sum with its flag and
// clears the bin, waiting while the previous response still waits on rsp_ready. Words with
// positions outside MAX_ROWS x MAX_COLS are dropped (a read still returns zero), and command 3
// is dropped. One word is in flight at a time, so the bin read-modify-write never overlaps
// another access. After reset the bin memory is swept to zero, one entry per cycle, over all
// MAX_ROWS * MAX_COLS entries; req_ready stays low during the sweep while register writes are
// still taken. Pedestal entries must be loaded before pixels use them unless bypass is set.
module pedestal_add_pixel_binner_unit #(
   parameter int MAX_ROWS = 512,
   parameter int MAX_COLS = 512
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  papb_pkg::papb_req_type                req_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output papb_pkg::papb_rsp_type                rsp_data,
   input  logic                                  csr_write,
   input  logic [papb_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [papb_pkg::CSR_DATA_W-1:0]       csr_wdata
);

   import papb_pkg::*;

   localparam int DEPTH  = MAX_ROWS * MAX_COLS;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int BIN_W  = $bits(papb_bin_type);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_ADD,
      ST_WRITE,
      ST_RESULT
   } state_type;

   // registers and their next values
   state_type          state_ff, state_in;
   logic [ADDR_W-1:0]  clr_ff, clr_in;
   logic [SHIFT_W-1:0] bin_shift_ff, bin_shift_in;
   logic               bypass_ff, bypass_in;
   papb_req_type       item_ff, item_in;
   logic [ADDR_W-1:0]  bin_addr_ff, bin_addr_in;
   logic               in_range_ff, in_range_in;
   logic [ADD_W-1:0]   add_ff, add_in;
   logic               rsp_valid_ff, rsp_valid_in;
   papb_rsp_type       rsp_data_ff, rsp_data_in;

   // accept-side decode
   logic               accept;
   logic               pos_ok;
   logic [SHIFT_W-1:0] shift;
   logic [POS_W-1:0]   bin_row;
   logic [POS_W-1:0]   bin_col;
   logic [ADDR_W-1:0]  pix_addr;
   logic [ADDR_W-1:0]  bin_addr;
   logic               out_free;

   // memory ports
   logic               ped_wr_en;
   logic               ped_rd_en;
   logic [PED_W-1:0]   ped_rd_data;
   logic               bin_wr_en;
   logic [ADDR_W-1:0]  bin_wr_addr;
   papb_bin_type       bin_wr_data;
   logic               bin_rd_en;
   papb_bin_type       bin_rd_data;
   logic [SUM_W:0]     total;
   papb_bin_type       bin_next;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   assign pos_ok = (int'(req_data.row) < MAX_ROWS) && (int'(req_data.column) < MAX_COLS);

   // clamp the bin shift to its largest meaningful value
   assign shift = (bin_shift_ff > SHIFT_MAX) ? SHIFT_MAX : bin_shift_ff;

   // a read names the bin directly; a pixel names it through the shift
   assign bin_row = (req_data.command == CMD_READ) ? req_data.row    : (req_data.row >> shift);
   assign bin_col = (req_data.command == CMD_READ) ? req_data.column : (req_data.column >> shift);

   assign pix_addr = ADDR_W'(int'(req_data.row) * MAX_COLS + int'(req_data.column));
   assign bin_addr = ADDR_W'(int'(bin_row) * MAX_COLS + int'(bin_col));

   assign ped_wr_en = accept && pos_ok && (req_data.command == CMD_LOAD);
   assign ped_rd_en = accept && pos_ok && (req_data.command == CMD_PIXEL);
   assign bin_rd_en = accept && pos_ok &&
                      ((req_data.command == CMD_PIXEL) || (req_data.command == CMD_READ));

   // saturating accumulate; the flag is sticky until the bin is read
   assign total = {1'b0, bin_rd_data.sum} + (SUM_W + 1)'(add_ff);

   always_comb begin
      if (total[SUM_W]) begin
         bin_next.sum       = '1;
         bin_next.saturated = 1'b1;
      end else begin
         bin_next.sum       = total[SUM_W-1:0];
         bin_next.saturated = bin_rd_data.saturated;
      end
   end

   // bin write port: clearing sweep, accumulate write-back, or clear on read
   always_comb begin
      bin_wr_en   = 1'b0;
      bin_wr_addr = bin_addr_ff;
      bin_wr_data = '0;
      case (state_ff)
         ST_CLEAR: begin
            bin_wr_en   = 1'b1;
            bin_wr_addr = clr_ff;
         end
         ST_WRITE: begin
            bin_wr_en   = 1'b1;
            bin_wr_data = bin_next;
         end
         ST_RESULT: begin
            bin_wr_en = out_free && in_range_ff;
         end
         default: begin
            bin_wr_en = 1'b0;
         end
      endcase
   end

   // next-state and next-value logic
   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      bin_shift_in = bin_shift_ff;
      bypass_in    = bypass_ff;
      item_in      = item_ff;
      bin_addr_in  = bin_addr_ff;
      in_range_in  = in_range_ff;
      add_in       = add_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;

      if (csr_write) begin
         if (csr_index == CSR_BIN_SHIFT) begin
            bin_shift_in = csr_wdata;
         end else if (csr_index == CSR_BYPASS) begin
            bypass_in = csr_wdata[0];
         end
      end

      case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + 1'b1;
            if (clr_ff == ADDR_W'(DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               item_in     = req_data;
               bin_addr_in = bin_addr;
               in_range_in = pos_ok;
               if (req_data.command == CMD_READ) begin
                  state_in = ST_RESULT;
               end else if (req_data.command == CMD_PIXEL && pos_ok) begin
                  state_in = ST_ADD;
               end
            end
         end
         ST_ADD: begin
            add_in   = ADD_W'(item_ff.sample) +
                       ADD_W'(bypass_ff ? PED_OFFSET : ped_rd_data);
            state_in = ST_WRITE;
         end
         ST_WRITE: begin
            state_in = ST_IDLE;
         end
         ST_RESULT: begin
            // hold until the output register is free
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (in_range_ff) begin
                  rsp_data_in.bin_sum   = bin_rd_data.sum;
                  rsp_data_in.saturated = bin_rd_data.saturated;
               end else begin
                  rsp_data_in = '0;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         bin_shift_ff <= '0;
         bypass_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         bin_shift_ff <= bin_shift_in;
         bypass_ff    <= bypass_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      item_ff     <= item_in;
      bin_addr_ff <= bin_addr_in;
      in_range_ff <= in_range_in;
      add_ff      <= add_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // per-pixel pedestal store
   papb_ram #(
      .WIDTH (PED_W),
      .DEPTH (DEPTH)
   ) u_ped_ram (
      .clock   (clock),
      .wr_en   (ped_wr_en),
      .wr_addr (pix_addr),
      .wr_data (req_data.pedestal_word),
      .rd_en   (ped_rd_en),
      .rd_addr (pix_addr),
      .rd_data (ped_rd_data)
   );

   // binned image: sum and sticky saturation flag per bin
   papb_ram #(
      .WIDTH (BIN_W),
      .DEPTH (DEPTH)
   ) u_bin_ram (
      .clock   (clock),
      .wr_en   (bin_wr_en),
      .wr_addr (bin_wr_addr),
      .wr_data (bin_wr_data),
      .rd_en   (bin_rd_en),
      .rd_addr (bin_addr),
      .rd_data (bin_rd_data)
   );

endmodule

/* hdl/papb_checker.sv */
`include "assert_macros.svh"

module papb_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_ready,
   input papb_pkg::papb_req_type req_data,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input papb_pkg::papb_rsp_type rsp_data
);

   import papb_pkg::*;

   // no response may be pending right after reset
   `ASSERT_ALWAYS(a_rsp_idle_after_reset, clock, reset |=> !rsp_valid, "response after reset")

   // an accepted read word moves the block into its result state, so req_ready falls
   `ASSERT_CLK(a_read_blocks, clock, reset, req_valid && req_ready && req_data.command == CMD_READ |=> !req_ready, "ready high after read accept")

   // a new response only rises after req_ready was low
   `ASSERT_CLK(a_rsp_from_busy, clock, reset, $rose(rsp_valid) |-> !$past(req_ready), "response without work in flight")

   // a stalled response holds
   `ASSERT_CLK(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data), "response changed while stalled")

endmodule

bind pedestal_add_pixel_binner_unit papb_checker u_papb_checker (.*);

/* tb/papb_checker.sv */
`timescale 1ns / 100ps

module papb_scoreboard (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_ready,
   input  papb_pkg::papb_req_type          req_data,
   input  logic                            rsp_valid,
   input  logic                            rsp_ready,
   input  papb_pkg::papb_rsp_type          rsp_data,
   input  logic                            csr_write,
   input  logic [papb_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [papb_pkg::CSR_DATA_W-1:0] csr_wdata,
   input  logic                            end_of_test,
   output int                              readouts_pending,
   output int                              error_count
);

   import papb_pkg::*;

   localparam int GRID_COLS  = 512;
   localparam int GRID_CELLS = 512 * 512;

   // mirror of the pedestal table, the binned image and the sticky flags
   bit [PED_W-1:0]   ped_mirror [GRID_CELLS];
   bit [SUM_W-1:0]   sum_mirror [GRID_CELLS];
   bit               sat_mirror [GRID_CELLS];
   bit [SHIFT_W-1:0] shift_cfg;
   bit               bypass_cfg;
   papb_rsp_type     bin_readouts_due [$];
   bit               leftovers_done;

   function automatic int cell_of(input logic [POS_W-1:0] r, input logic [POS_W-1:0] c);
      return int'(r) * GRID_COLS + int'(c);
   endfunction

   task automatic report_mismatch(input string what);
      $display("%0t papb_checker: %s", $time, what);
      error_count++;
   endtask

   // 9-bit positions always fall inside the 512 x 512 grid
   task automatic mirror_word(input papb_req_type w);
      logic [SHIFT_W-1:0] sh;
      logic [ADD_W-1:0]   corrected;
      logic [SUM_W:0]     total;
      int                 slot;
      papb_rsp_type       due;
      case (w.command)
         CMD_LOAD:
            ped_mirror[cell_of(w.row, w.column)] = w.pedestal_word;
         CMD_PIXEL: begin
            sh = (shift_cfg > SHIFT_MAX) ? SHIFT_MAX : shift_cfg;
            corrected = w.sample +
                        (bypass_cfg ? PED_OFFSET : ped_mirror[cell_of(w.row, w.column)]);
            slot = cell_of(w.row >> sh, w.column >> sh);
            total = sum_mirror[slot] + corrected;
            if (total[SUM_W]) begin
               sum_mirror[slot] = '1;
               sat_mirror[slot] = 1'b1;
            end else
               sum_mirror[slot] = total[SUM_W-1:0];
         end
         CMD_READ: begin
            slot = cell_of(w.row, w.column);
            due.bin_sum   = sum_mirror[slot];
            due.saturated = sat_mirror[slot];
            bin_readouts_due = {bin_readouts_due, due};
            sum_mirror[slot] = '0;
            sat_mirror[slot] = 1'b0;
         end
         default: ;  // drop the unused command
      endcase
   endtask

   task automatic check_readout(input papb_rsp_type got);
      papb_rsp_type want;
      if (bin_readouts_due.size() == 0) begin
         report_mismatch($sformatf("readout with none due: sum %0d sat %0b",
                                   got.bin_sum, got.saturated));
         return;
      end
      want = bin_readouts_due.pop_front();
      if (got.bin_sum !== want.bin_sum)
         report_mismatch($sformatf("bin_sum %0d, want %0d", got.bin_sum, want.bin_sum));
      if (got.saturated !== want.saturated)
         report_mismatch($sformatf("saturated %b, want %b", got.saturated, want.saturated));
   endtask

   always @(posedge clock) begin
      if (reset) begin
         shift_cfg  = '0;
         bypass_cfg = 1'b0;
      end else begin
         if (csr_write) begin
            if (csr_index == CSR_BIN_SHIFT)
               shift_cfg = csr_wdata;
            else if (csr_index == CSR_BYPASS)
               bypass_cfg = csr_wdata[0];
         end
         if (req_valid && req_ready)
            mirror_word(req_data);
         if (rsp_valid && rsp_ready)
            check_readout(rsp_data);
         if (end_of_test && !leftovers_done) begin
            leftovers_done = 1'b1;
            foreach (bin_readouts_due[i])
               report_mismatch($sformatf("readout never came: sum %0d sat %0b",
                                         bin_readouts_due[i].bin_sum,
                                         bin_readouts_due[i].saturated));
            bin_readouts_due.delete();
         end
      end
      readouts_pending <= bin_readouts_due.size();
   end

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;
   import papb_pkg::*;

   localparam logic [1:0] CMD_UNUSED = 2'd3;
   localparam int PED_TOP        = 131071;
   localparam int SAMPLE_TOP     = 65535;
   localparam int DRAIN_CYCLES   = 8;    // slack for an in-flight pixel word to finish
   localparam int HOLDOFF_CYCLES = 400;
   localparam int PHASE_WORDS    = 100;
   localparam int PHASES         = 10;
   localparam int FILL_WORDS     = 40;   // max-value pixels piled into one bin

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   papb_req_type          req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   papb_rsp_type          rsp_data;
   logic                  csr_write = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;
   logic                  end_of_test = 1'b0;
   int                    readouts_pending;
   int                    error_count;

   // stimulus-side bookkeeping
   bit               sender_gaps   = 1'b1;
   bit               receiver_gaps = 1'b1;
   int               holdoff_asks  = 0;
   bit               loaded_map [512 * 512];
   bit [SHIFT_W-1:0] cur_shift;
   bit               cur_bypass;

   // per-phase register settings; shifts above four must act as four
   bit [SHIFT_W-1:0] phase_shift  [PHASES] = '{0, 1, 2, 3, 4, 4, 5, 6, 0, 2};
   bit               phase_bypass [PHASES] = '{0, 0, 1, 0, 1, 0, 1, 0, 1, 0};

   pedestal_add_pixel_binner_unit u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   papb_scoreboard u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_data         (rsp_data),
      .csr_write        (csr_write),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .end_of_test      (end_of_test),
      .readouts_pending (readouts_pending),
      .error_count      (error_count)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // The post-reset sweep alone takes about 5.2 ms; with about 1300 words on
   // top, the whole run sits well under a sixth of this.
   initial begin : watchdog
      #40000000;
      $display("pedestal_add_pixel_binner_unit regression: fail");
      $finish;
   end

   // Result side: random stalls, plus a long hold-off each time the
   // stimulus asks for one, counted here in cycles.
   initial begin : receiver
      int served;
      served = 0;
      forever begin
         @(posedge clock);
         if (served != holdoff_asks) begin
            served++;
            rsp_ready <= 1'b0;
            repeat (HOLDOFF_CYCLES) @(posedge clock);
         end else
            rsp_ready <= !(receiver_gaps && $urandom_range(0, 99) < 12);
      end
   end

   // Offer one word and hold it until it is taken. Valid is only lowered when
   // a gap is inserted, so it never drops and rises in the same step.
   // Most callers fill the fields the command does not use with random bits.
   task automatic send_word(input logic [1:0] cmd, input int r, input int c,
                            input int smp, input int ped);
      papb_req_type w;
      w.command       = cmd;
      w.row           = POS_W'(r);
      w.column        = POS_W'(c);
      w.sample        = SAMPLE_W'(smp);
      w.pedestal_word = PED_W'(ped);
      if (sender_gaps && $urandom_range(0, 99) < 12) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < 40);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic load_pedestal(input int r, input int c, input int ped);
      send_word(CMD_LOAD, r, c, $urandom, ped);
      loaded_map[r * 512 + c] = 1'b1;
   endtask

   // Never let a pixel read a pedestal that was not loaded: load it first.
   task automatic add_pixel(input int r, input int c, input int smp);
      if (!cur_bypass && !loaded_map[r * 512 + c])
         load_pedestal(r, c, $urandom_range(0, PED_TOP));
      send_word(CMD_PIXEL, r, c, smp, $urandom);
   endtask

   task automatic read_bin(input int r, input int c);
      send_word(CMD_READ, r, c, $urandom, $urandom);
   endtask

   // Drop valid, wait for every readout, then let in-flight pixel words finish.
   task automatic wait_quiet();
      req_valid <= 1'b0;
      do @(posedge clock); while (readouts_pending != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Write both registers back to back; the bypass word gets random upper bits.
   task automatic set_mode(input bit [SHIFT_W-1:0] shift_val, input bit bypass_val);
      logic [CSR_DATA_W-1:0] bypass_word;
      bypass_word    = CSR_DATA_W'($urandom);
      bypass_word[0] = bypass_val;
      csr_write <= 1'b1;
      csr_index <= CSR_BIN_SHIFT;
      csr_wdata <= shift_val;
      @(posedge clock);
      csr_index <= CSR_BYPASS;
      csr_wdata <= bypass_word;
      @(posedge clock);
      csr_write <= 1'b0;
      @(posedge clock);
      cur_shift  = (shift_val > SHIFT_MAX) ? SHIFT_MAX : shift_val;
      cur_bypass = bypass_val;
   endtask

   // Random traffic inside a window of 4 x 4 bins so reads find filled sums,
   // with some full-range noise. With squeeze set, hold off the receiver while
   // reads keep coming, and later pause until every readout is back.
   task automatic run_phase(input int words, input bit squeeze);
      int side, row0, col0, r, c, pick, smp, n, k;
      side = 4 << cur_shift;
      row0 = $urandom_range(0, 512 - side);
      col0 = $urandom_range(0, 512 - side);
      for (n = 0; n < words; n++) begin
         if (squeeze && n == words / 3) begin
            holdoff_asks <= holdoff_asks + 1;
            for (k = 0; k < 24; k++)
               read_bin((row0 >> cur_shift) + $urandom_range(0, 3),
                        (col0 >> cur_shift) + $urandom_range(0, 3));
         end
         if (squeeze && n == 2 * words / 3)
            wait_quiet();
         r    = row0 + $urandom_range(0, side - 1);
         c    = col0 + $urandom_range(0, side - 1);
         pick = $urandom_range(0, 99);
         smp  = $urandom_range(0, 99);
         smp  = (smp < 10) ? SAMPLE_TOP : (smp < 15) ? 0 : $urandom_range(0, SAMPLE_TOP);
         if (pick < 20)
            load_pedestal(r, c, $urandom_range(0, PED_TOP));
         else if (pick < 70)
            add_pixel(r, c, smp);
         else if (pick < 90)
            read_bin(r >> cur_shift, c >> cur_shift);
         else if (pick < 93)
            read_bin($urandom_range(0, 511), $urandom_range(0, 511));
         else if (pick < 96)
            load_pedestal($urandom_range(0, 511), $urandom_range(0, 511),
                          $urandom_range(0, PED_TOP));
         else if (pick < 98)
            send_word(CMD_UNUSED, $urandom, $urandom, $urandom, $urandom);
         else
            add_pixel($urandom_range(0, 511), $urandom_range(0, 511), smp);
      end
   endtask

   initial begin : stimulus
      int n, p;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Registers are taken during the clearing sweep; words wait for req_ready.
      set_mode(0, 0);

      // Directed: extremes of position, sample and pedestal, read-and-clear,
      // untouched bins and the unused command.
      load_pedestal(0, 0, 0);
      load_pedestal(511, 511, PED_TOP);
      load_pedestal(0, 511, 65536);
      load_pedestal(511, 0, $urandom_range(0, PED_TOP));
      add_pixel(0, 0, 0);
      add_pixel(0, 0, SAMPLE_TOP);
      add_pixel(511, 511, SAMPLE_TOP);
      add_pixel(0, 511, $urandom_range(0, SAMPLE_TOP));
      add_pixel(511, 0, 0);
      read_bin(0, 0);
      read_bin(511, 511);
      read_bin(511, 511);
      read_bin(0, 511);
      read_bin(100, 200);
      send_word(CMD_UNUSED, 511, 511, SAMPLE_TOP, PED_TOP);
      wait_quiet();

      // Out-of-range shift with bypass: the first two pixels fold into bin (31, 31).
      set_mode(7, 1);
      add_pixel(511, 511, SAMPLE_TOP);
      add_pixel(496, 500, 0);
      add_pixel(0, 0, 1);
      read_bin(31, 31);
      read_bin(31, 31);
      read_bin(0, 0);
      read_bin(511, 0);
      wait_quiet();

      // Large sums: pile max-value pixels into bin (255, 255) from two
      // positions, add zero there, then read it back and read it cleared.
      set_mode(1, 0);
      load_pedestal(511, 511, PED_TOP);
      load_pedestal(510, 510, 43690);
      load_pedestal(510, 511, 0);
      for (n = 0; n < FILL_WORDS; n++)
         add_pixel(511, 511, SAMPLE_TOP);
      add_pixel(510, 510, SAMPLE_TOP);
      add_pixel(510, 511, 0);
      add_pixel(510, 511, 1);
      add_pixel(511, 511, SAMPLE_TOP);
      read_bin(255, 255);
      read_bin(255, 255);

      // Random phases; one runs with no idling on either side.
      for (p = 0; p < PHASES; p++) begin
         wait_quiet();
         set_mode(phase_shift[p], phase_bypass[p]);
         sender_gaps   = (p != 4);
         receiver_gaps = (p != 4);
         run_phase(PHASE_WORDS, p == 2);
      end

      wait_quiet();
      end_of_test <= 1'b1;
      repeat (2) @(posedge clock);
      if (error_count == 0)
         $display("pedestal_add_pixel_binner_unit regression: pass");
      else
         $display("pedestal_add_pixel_binner_unit regression: fail");
      $finish;
   end

endmodule

/* files.f */
+incdir+hdl
hdl/papb_pkg.sv
hdl/papb_ram.sv
hdl/pedestal_add_pixel_binner_unit.sv
hdl/papb_checker.sv
tb/papb_checker.sv
tb/tb_top.sv
